// ----- rtl/rmst_pkg.sv -----
package rmst_pkg;

   localparam int DEFAULT_MAX_LEAVES = 1024;

   localparam int CSR_W       = 11;
   localparam int POS_FIELD_W = 11;
   localparam int VALUE_W     = 32;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 32;

   localparam logic [CSR_W-1:0]   LEAF_COUNT_RESET = 11'd1024;
   localparam logic [VALUE_W-1:0] VALUE_MIN        = 32'h8000_0000;

   typedef enum logic {
      CMD_ASSIGN = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_LEAF,
      ST_RD_RIGHT,
      ST_UPDATE,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      PH_FRESH,
      PH_RIGHT,
      PH_POST
   } phase_type;

endpackage

// ----- rtl/range_max_segment_tree.sv -----
// Range-maximum segment tree over signed 32-bit leaves at positions 1..leaf_count.
// A request either assigns a value to every leaf in [lo, hi] or returns the largest
// leaf value in [lo, hi]; each request gives exactly one response, and a bad range
// (lo of zero, lo above hi, hi above the leaf count) is answered with range_error
// set and the store left alone. The node store is a single-port memory and all
// value comparisons go through one signed compare unit, so a request is worked
// through a frame stack node by node. A query reads each leaf in the range and
// folds it into a running maximum; an assign writes each such leaf and then, on
// the way back up, reads the left and then the right child of each inner node it
// passed and writes back the larger. A node that splits the range pushes its right
// child once its left subtree is done, and a rejected request goes straight to its
// response. req_tready is low while a request is being worked. After reset the
// store is cleared one entry per cycle, with req_tready low; csr writes are taken
// at any time but must only be issued while the block is idle.
module range_max_segment_tree #(
   parameter int MAX_LEAVES = rmst_pkg::DEFAULT_MAX_LEAVES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rmst_pkg::REQ_TDATA_W-1:0] req_tdata,  // lo, hi, value
   input  logic [0:0]                       req_tuser,  // command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rmst_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // max_value
   output logic [0:0]                       rsp_tuser,  // range_error
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rmst_pkg::CSR_W-1:0]       csr_data    // leaf_count
);

   localparam int POS_W = $clog2(MAX_LEAVES + 1);
   localparam int ID_W  = $clog2(MAX_LEAVES) + 1;

   logic [rmst_pkg::CSR_W-1:0]       leaf_count_ff, leaf_count_in;
   logic [POS_W-1:0]                 n_eff;
   logic [rmst_pkg::POS_FIELD_W-1:0] req_lo, req_hi;
   logic [rmst_pkg::VALUE_W-1:0]     req_value;
   logic                             rsp_error;

   logic                         mem_en, mem_we;
   logic [ID_W-1:0]              mem_addr;
   logic [rmst_pkg::VALUE_W-1:0] mem_wdata, mem_rdata;

   assign csr_ready     = 1'b1;
   assign leaf_count_in = csr_valid ? csr_data : leaf_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= rmst_pkg::LEAF_COUNT_RESET;
      end else begin
         leaf_count_ff <= leaf_count_in;
      end
   end

   // leaf count saturates at MAX_LEAVES
   assign n_eff = (32'(leaf_count_ff) > 32'(MAX_LEAVES)) ? POS_W'(MAX_LEAVES)
                                                         : POS_W'(leaf_count_ff);

   assign req_lo    = req_tdata[10:0];
   assign req_hi    = req_tdata[21:11];
   assign req_value = req_tdata[53:22];

   rmst_walker #(
      .MAX_LEAVES (MAX_LEAVES),
      .POS_W      (POS_W),
      .ID_W       (ID_W)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .n_eff     (n_eff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser[0]),
      .req_lo    (req_lo),
      .req_hi    (req_hi),
      .req_value (req_value),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_tdata),
      .rsp_error (rsp_error),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   assign rsp_tuser[0] = rsp_error;

   rmst_node_ram #(
      .ADDR_W (ID_W)
   ) u_ram (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule

// ----- rtl/rmst_max_unit.sv -----
module rmst_max_unit (
   input  logic [rmst_pkg::VALUE_W-1:0] op_a,
   input  logic [rmst_pkg::VALUE_W-1:0] op_b,
   output logic [rmst_pkg::VALUE_W-1:0] larger
);

   // signed compare, ties keep the first operand
   assign larger = ($signed(op_a) >= $signed(op_b)) ? op_a : op_b;

endmodule

// ----- rtl/rmst_node_ram.sv -----
module rmst_node_ram #(
   parameter int ADDR_W = 11
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic                         we,
   input  logic [ADDR_W-1:0]            addr,
   input  logic [rmst_pkg::VALUE_W-1:0] wdata,
   output logic [rmst_pkg::VALUE_W-1:0] rdata
);

   logic [rmst_pkg::VALUE_W-1:0] mem [2**ADDR_W];
   logic [rmst_pkg::VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/rmst_walker.sv -----
module rmst_walker #(
   parameter int MAX_LEAVES = rmst_pkg::DEFAULT_MAX_LEAVES,
   parameter int POS_W      = $clog2(MAX_LEAVES + 1),
   parameter int ID_W       = $clog2(MAX_LEAVES) + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [POS_W-1:0]                 n_eff,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [rmst_pkg::POS_FIELD_W-1:0] req_lo,
   input  logic [rmst_pkg::POS_FIELD_W-1:0] req_hi,
   input  logic [rmst_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rmst_pkg::VALUE_W-1:0]     rsp_value,
   output logic                             rsp_error,
   output logic                             mem_en,
   output logic                             mem_we,
   output logic [ID_W-1:0]                  mem_addr,
   output logic [rmst_pkg::VALUE_W-1:0]     mem_wdata,
   input  logic [rmst_pkg::VALUE_W-1:0]     mem_rdata
);

   localparam int STACK_D = ID_W;
   localparam int SP_W    = $clog2(STACK_D);

   rmst_pkg::state_type state_ff, state_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic [ID_W-1:0]     clr_ff, clr_in;
   logic                err_ff, err_in;
   logic                rsp_valid_ff, rsp_valid_in;

   rmst_pkg::cmd_type            cmd_ff, cmd_in;
   logic [rmst_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [rmst_pkg::VALUE_W-1:0] acc_ff, acc_in;
   logic [rmst_pkg::VALUE_W-1:0] left_ff, left_in;
   logic [rmst_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_error_ff, rsp_error_in;

   // frame stack, one entry per tree level
   logic [ID_W-1:0]       stk_id_ff    [STACK_D];
   logic [POS_W-1:0]      stk_a_ff     [STACK_D];
   logic [POS_W-1:0]      stk_b_ff     [STACK_D];
   logic [POS_W-1:0]      stk_lo_ff    [STACK_D];
   logic [POS_W-1:0]      stk_hi_ff    [STACK_D];
   rmst_pkg::phase_type   stk_phase_ff [STACK_D];

   logic                  fr_we;
   logic [SP_W-1:0]       fr_idx;
   logic [ID_W-1:0]       fr_id;
   logic [POS_W-1:0]      fr_a, fr_b, fr_lo, fr_hi;
   rmst_pkg::phase_type   fr_phase;
   logic                  ph_we;
   rmst_pkg::phase_type   ph_in;
   logic                  do_pop;

   logic [ID_W-1:0]       t_id;
   logic [POS_W-1:0]      t_a, t_b, t_lo, t_hi;
   rmst_pkg::phase_type   t_phase;
   logic [POS_W:0]        span_sum;
   logic [POS_W-1:0]      mid, mid_next;
   logic [ID_W-1:0]       left_id, right_id;
   logic                  req_bad;

   logic [rmst_pkg::VALUE_W-1:0] op_a, larger;

   assign t_id    = stk_id_ff[sp_ff];
   assign t_a     = stk_a_ff[sp_ff];
   assign t_b     = stk_b_ff[sp_ff];
   assign t_lo    = stk_lo_ff[sp_ff];
   assign t_hi    = stk_hi_ff[sp_ff];
   assign t_phase = stk_phase_ff[sp_ff];

   assign span_sum = {1'b0, t_a} + {1'b0, t_b};
   assign mid      = span_sum[POS_W:1];
   assign mid_next = mid + POS_W'(1);
   assign left_id  = {t_id[ID_W-2:0], 1'b0};
   assign right_id = {t_id[ID_W-2:0], 1'b1};

   assign req_bad = (n_eff == '0) || (req_lo == '0) || (req_lo > req_hi) ||
                    (32'(req_hi) > 32'(n_eff));

   assign op_a = (state_ff == rmst_pkg::ST_UPDATE) ? left_ff : acc_ff;

   rmst_max_unit u_max (
      .op_a   (op_a),
      .op_b   (mem_rdata),
      .larger (larger)
   );

   assign req_ready = (state_ff == rmst_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      clr_in       = clr_ff;
      err_in       = err_ff;
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;

      fr_we    = 1'b0;
      fr_idx   = sp_ff + 1'b1;
      fr_id    = left_id;
      fr_a     = t_a;
      fr_b     = mid;
      fr_lo    = t_lo;
      fr_hi    = t_hi;
      fr_phase = rmst_pkg::PH_FRESH;
      ph_we    = 1'b0;
      ph_in    = rmst_pkg::PH_POST;
      do_pop   = 1'b0;

      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = t_id;
      mem_wdata = value_ff;

      case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = rmst_pkg::ST_IDLE;
            end
         end

         rmst_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = rmst_pkg::cmd_type'(req_cmd);
               value_in = req_value;
               acc_in   = rmst_pkg::VALUE_MIN;
               if (req_bad) begin
                  err_in   = 1'b1;
                  state_in = rmst_pkg::ST_RESP;
               end else begin
                  err_in   = 1'b0;
                  fr_we    = 1'b1;
                  fr_idx   = '0;
                  fr_id    = ID_W'(1);
                  fr_a     = POS_W'(1);
                  fr_b     = n_eff;
                  fr_lo    = POS_W'(req_lo);
                  fr_hi    = POS_W'(req_hi);
                  sp_in    = '0;
                  state_in = rmst_pkg::ST_WALK;
               end
            end
         end

         rmst_pkg::ST_WALK: begin
            case (t_phase)
               rmst_pkg::PH_FRESH: begin
                  if (t_a == t_b) begin
                     mem_en = 1'b1;
                     if (cmd_ff == rmst_pkg::CMD_ASSIGN) begin
                        mem_we = 1'b1;
                        do_pop = 1'b1;
                     end else begin
                        state_in = rmst_pkg::ST_LEAF;
                     end
                  end else begin
                     fr_we = 1'b1;
                     ph_we = 1'b1;
                     sp_in = sp_ff + 1'b1;
                     if (t_hi <= mid) begin
                        ph_in = rmst_pkg::PH_POST;
                     end else if (t_lo > mid) begin
                        fr_id = right_id;
                        fr_a  = mid_next;
                        fr_b  = t_b;
                        ph_in = rmst_pkg::PH_POST;
                     end else begin
                        fr_hi = mid;
                        ph_in = rmst_pkg::PH_RIGHT;
                     end
                  end
               end

               rmst_pkg::PH_RIGHT: begin
                  fr_we = 1'b1;
                  fr_id = right_id;
                  fr_a  = mid_next;
                  fr_b  = t_b;
                  fr_lo = mid_next;
                  ph_we = 1'b1;
                  ph_in = rmst_pkg::PH_POST;
                  sp_in = sp_ff + 1'b1;
               end

               rmst_pkg::PH_POST: begin
                  if (cmd_ff == rmst_pkg::CMD_ASSIGN) begin
                     mem_en   = 1'b1;
                     mem_addr = left_id;
                     state_in = rmst_pkg::ST_RD_RIGHT;
                  end else begin
                     do_pop = 1'b1;
                  end
               end

               default: begin
                  do_pop = 1'b1;
               end
            endcase
         end

         rmst_pkg::ST_LEAF: begin
            acc_in = larger;
            do_pop = 1'b1;
         end

         rmst_pkg::ST_RD_RIGHT: begin
            left_in  = mem_rdata;
            mem_en   = 1'b1;
            mem_addr = right_id;
            state_in = rmst_pkg::ST_UPDATE;
         end

         rmst_pkg::ST_UPDATE: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = larger;
            do_pop    = 1'b1;
         end

         rmst_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_error_in = err_ff;
               rsp_value_in = (err_ff || cmd_ff == rmst_pkg::CMD_ASSIGN) ? '0 : acc_ff;
               state_in     = rmst_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rmst_pkg::ST_IDLE;
         end
      endcase

      if (do_pop) begin
         if (sp_ff == '0) begin
            state_in = rmst_pkg::ST_RESP;
         end else begin
            sp_in    = sp_ff - 1'b1;
            state_in = rmst_pkg::ST_WALK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmst_pkg::ST_CLEAR;
         sp_ff        <= '0;
         clr_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         clr_ff       <= clr_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      value_ff     <= value_in;
      acc_ff       <= acc_in;
      left_ff      <= left_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
      if (fr_we) begin
         stk_id_ff[fr_idx]    <= fr_id;
         stk_a_ff[fr_idx]     <= fr_a;
         stk_b_ff[fr_idx]     <= fr_b;
         stk_lo_ff[fr_idx]    <= fr_lo;
         stk_hi_ff[fr_idx]    <= fr_hi;
         stk_phase_ff[fr_idx] <= fr_phase;
      end
      if (ph_we) begin
         stk_phase_ff[sp_ff] <= ph_in;
      end
   end

endmodule

// ----- rtl/rmst_checker.sv -----
module rmst_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rmst_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]                       rsp_tuser
);

   // a request blocks further requests while it is worked
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted on back-to-back cycles");

   // clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !req_tready)
      else $error("request taken before store clear");

   // a rejected range carries a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("error response with nonzero value");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                      $stable(rsp_tuser)))
      else $error("response changed while stalled");

endmodule

bind range_max_segment_tree rmst_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
